/* sv/mlbc_pkg.sv */
// ----------------------------------------------------------------------------
// mlbc_pkg
// Shared types and constants for the multi-channel LED blink controller.
// ----------------------------------------------------------------------------
package mlbc_pkg;

   localparam int NUM_CHANNELS_DEF = 8;
   localparam int MAX_CHANNELS     = 16;
   localparam int TYPE_W           = 3;
   localparam int INDEX_W          = 4;
   localparam int TICKS_W          = 16;
   localparam int COUNT_W          = 16;
   localparam int LEVELS_W         = 8;

   localparam logic [TYPE_W-1:0] REQ_SET           = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_TOGGLE        = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_BLINK_FOREVER = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_BLINK_OFF     = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_BLINK_TOGGLE  = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_BLINK_TIMES   = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_TICK          = 3'd6;

   // command beat as seen by every channel
   typedef struct packed {
      logic [TYPE_W-1:0]  code;
      logic               level_on;
      logic [TICKS_W-1:0] interval;
      logic [COUNT_W-1:0] count;
      logic               interval_nz;
      logic               count_nz;
   } cmd_type;

endpackage

/* sv/mlbc_channel.sv */
// ----------------------------------------------------------------------------
// mlbc_channel
// State and update logic of one LED channel: level, blink mode, timers.
// ----------------------------------------------------------------------------
module mlbc_channel (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  logic              sel,
   input  mlbc_pkg::cmd_type cmd,
   output logic              level,
   output logic              blinking
);

   logic                         level_ff, level_in;
   logic                         blinking_ff, blinking_in;
   logic                         saved_ff, saved_in;
   logic                         forever_ff, forever_in;
   logic [mlbc_pkg::TICKS_W-1:0] interval_ff, interval_in;
   logic [mlbc_pkg::TICKS_W-1:0] elapsed_ff, elapsed_in;
   logic [mlbc_pkg::COUNT_W-1:0] cycles_ff, cycles_in;

   logic [mlbc_pkg::TICKS_W-1:0] elapsed_inc;
   logic [mlbc_pkg::COUNT_W-1:0] cycles_dec;
   logic                         start_forever;
   logic                         start_times;

   assign elapsed_inc = elapsed_ff + mlbc_pkg::TICKS_W'(1);
   assign cycles_dec  = (cycles_ff != '0) ? cycles_ff - mlbc_pkg::COUNT_W'(1) : '0;

   always_comb begin
      level_in      = level_ff;
      blinking_in   = blinking_ff;
      saved_in      = saved_ff;
      forever_in    = forever_ff;
      interval_in   = interval_ff;
      elapsed_in    = elapsed_ff;
      cycles_in     = cycles_ff;
      start_forever = 1'b0;
      start_times   = 1'b0;
      if (cmd_valid) begin
         case (cmd.code)
            mlbc_pkg::REQ_SET: begin
               if (sel) begin
                  blinking_in = 1'b0;
                  level_in    = cmd.level_on;
               end
            end
            mlbc_pkg::REQ_TOGGLE: begin
               if (sel) begin
                  blinking_in = 1'b0;
                  level_in    = ~level_ff;
               end
            end
            mlbc_pkg::REQ_BLINK_FOREVER: begin
               start_forever = sel && cmd.interval_nz;
            end
            mlbc_pkg::REQ_BLINK_OFF: begin
               if (sel && blinking_ff) begin
                  blinking_in = 1'b0;
                  level_in    = saved_ff;
               end
            end
            mlbc_pkg::REQ_BLINK_TOGGLE: begin
               if (sel && cmd.interval_nz) begin
                  if (blinking_ff) begin
                     blinking_in = 1'b0;
                     level_in    = saved_ff;
                  end else begin
                     start_forever = 1'b1;
                  end
               end
            end
            mlbc_pkg::REQ_BLINK_TIMES: begin
               start_times = sel && cmd.interval_nz && cmd.count_nz;
            end
            mlbc_pkg::REQ_TICK: begin
               if (blinking_ff) begin
                  if (elapsed_inc < interval_ff) begin
                     elapsed_in = elapsed_inc;
                  end else begin
                     elapsed_in = '0;
                     level_in   = ~level_ff;
                     if (!forever_ff && (~level_ff == saved_ff)) begin
                        cycles_in = cycles_dec;
                        if (cycles_dec == '0) begin
                           blinking_in = 1'b0;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (start_forever || start_times) begin
         blinking_in = 1'b1;
         saved_in    = level_ff;
         interval_in = cmd.interval;
         elapsed_in  = '0;
         cycles_in   = start_times ? cmd.count : '0;
         forever_in  = start_forever;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= 1'b0;
         blinking_ff <= 1'b0;
         saved_ff    <= 1'b0;
         forever_ff  <= 1'b0;
         interval_ff <= '0;
         elapsed_ff  <= '0;
         cycles_ff   <= '0;
      end else begin
         level_ff    <= level_in;
         blinking_ff <= blinking_in;
         saved_ff    <= saved_in;
         forever_ff  <= forever_in;
         interval_ff <= interval_in;
         elapsed_ff  <= elapsed_in;
         cycles_ff   <= cycles_in;
      end
   end

   assign level    = level_ff;
   assign blinking = blinking_ff;

endmodule

/* sv/multi_led_blink_controller.sv */
// ----------------------------------------------------------------------------
// multi_led_blink_controller
// Per-channel LED controller with static levels, counted and endless blinking.
//
//   channel  ports                         handshake
//   request  req_*                         start high, busy low at clock edge
//   result   rsp_*                         rsp_valid for one cycle, no stall
//
// One beat per cycle while busy is low. The beat edge registers the command
// and the next edge applies it to all channels in parallel, so the result is
// on rsp_* in the cycle after that edge.
// The result shows the channel state right after the command was applied.
// busy is set while reset is high and cleared by the clock edge after reset is released.
// The receiver cannot stall, so nothing ever waits on the result side.
// ----------------------------------------------------------------------------
module multi_led_blink_controller #(
   parameter int NUM_CHANNELS = mlbc_pkg::NUM_CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mlbc_pkg::TYPE_W-1:0]    req_type,
   input  logic [mlbc_pkg::INDEX_W-1:0]   req_led_index,
   input  logic                           req_level_on,
   input  logic [mlbc_pkg::TICKS_W-1:0]   req_interval_ticks,
   input  logic [mlbc_pkg::COUNT_W-1:0]   req_blink_count,
   output logic                           rsp_valid,
   output logic [mlbc_pkg::LEVELS_W-1:0]  rsp_led_levels,
   output logic [mlbc_pkg::LEVELS_W-1:0]  rsp_blinking_mask,
   output logic                           rsp_accepted
);

   logic                           busy_ff;
   logic                           cmd_valid_ff;
   mlbc_pkg::cmd_type              cmd_ff, cmd_in;
   logic [mlbc_pkg::INDEX_W-1:0]   index_ff;
   logic                           rsp_valid_ff;
   logic                           accepted_ff, accepted_in;
   logic                           index_ok;
   logic [NUM_CHANNELS-1:0]        chan_level;
   logic [NUM_CHANNELS-1:0]        chan_blinking;

   always_comb begin
      cmd_in.code        = req_type;
      cmd_in.level_on    = req_level_on;
      cmd_in.interval    = req_interval_ticks;
      cmd_in.count       = req_blink_count;
      cmd_in.interval_nz = (req_interval_ticks != '0);
      cmd_in.count_nz    = (req_blink_count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         cmd_valid_ff <= start && !busy_ff;
         rsp_valid_ff <= cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         cmd_ff   <= cmd_in;
         index_ff <= req_led_index;
      end
      accepted_ff <= accepted_in;
   end

   assign index_ok = {1'b0, index_ff} < (mlbc_pkg::INDEX_W + 1)'(NUM_CHANNELS);

   always_comb begin
      case (cmd_ff.code)
         mlbc_pkg::REQ_SET,
         mlbc_pkg::REQ_TOGGLE,
         mlbc_pkg::REQ_BLINK_OFF:     accepted_in = index_ok;
         mlbc_pkg::REQ_BLINK_FOREVER,
         mlbc_pkg::REQ_BLINK_TOGGLE:  accepted_in = index_ok && cmd_ff.interval_nz;
         mlbc_pkg::REQ_BLINK_TIMES:   accepted_in = index_ok && cmd_ff.interval_nz
                                                    && cmd_ff.count_nz;
         mlbc_pkg::REQ_TICK:          accepted_in = 1'b1;
         default:                     accepted_in = 1'b0;
      endcase
   end

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      mlbc_channel u_chan (
         .clock     (clock),
         .reset     (reset),
         .cmd_valid (cmd_valid_ff),
         .sel       (index_ff == mlbc_pkg::INDEX_W'(i)),
         .cmd       (cmd_ff),
         .level     (chan_level[i]),
         .blinking  (chan_blinking[i])
      );
   end

   for (genvar j = 0; j < mlbc_pkg::LEVELS_W; j++) begin : g_out
      if (j < NUM_CHANNELS) begin : g_used
         assign rsp_led_levels[j]    = chan_level[j];
         assign rsp_blinking_mask[j] = chan_blinking[j];
      end else begin : g_unused
         assign rsp_led_levels[j]    = 1'b0;
         assign rsp_blinking_mask[j] = 1'b0;
      end
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = accepted_ff;

endmodule

/* sv/mlbc_checker.sv */
// ----------------------------------------------------------------------------
// mlbc_port_checker
// Port-level checks of beat timing and command acceptance.
// ----------------------------------------------------------------------------
module mlbc_port_checker #(
   parameter int NUM_CHANNELS = mlbc_pkg::NUM_CHANNELS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [mlbc_pkg::TYPE_W-1:0]   req_type,
   input logic [mlbc_pkg::INDEX_W-1:0]  req_led_index,
   input logic                          rsp_valid,
   input logic                          rsp_accepted
);

   logic beat;
   assign beat = start && !busy;

   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy outside reset recovery");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      beat |-> ##2 rsp_valid)
      else $error("request beat without result");

   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(beat, 2))
      else $error("result without request beat");

   a_tick_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(beat && (req_type == mlbc_pkg::REQ_TICK), 2))
      |-> rsp_accepted)
      else $error("tick not accepted");

   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(beat && (req_type != mlbc_pkg::REQ_TICK)
         && ({1'b0, req_led_index} >= (mlbc_pkg::INDEX_W + 1)'(NUM_CHANNELS)), 2))
      |-> !rsp_accepted)
      else $error("command on missing channel accepted");

endmodule

bind multi_led_blink_controller mlbc_port_checker #(.NUM_CHANNELS(NUM_CHANNELS))
   u_mlbc_port_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_type      (req_type),
   .req_led_index (req_led_index),
   .rsp_valid     (rsp_valid),
   .rsp_accepted  (rsp_accepted)
);

/* verif/mlbc_checker.sv */
// ----------------------------------------------------------------------------
// mlbc_checker
// Watches the request and result ports of the LED blink controller. It keeps
// its own copy of every channel and predicts the level and blink vectors and
// the accepted flag for each beat. Each result is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module mlbc_checker
   import mlbc_pkg::*;
#(
   parameter int NCH = NUM_CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [TYPE_W-1:0]    req_type,
   input  logic [INDEX_W-1:0]   req_led_index,
   input  logic                 req_level_on,
   input  logic [TICKS_W-1:0]   req_interval_ticks,
   input  logic [COUNT_W-1:0]   req_blink_count,
   input  logic                 rsp_valid,
   input  logic [LEVELS_W-1:0]  rsp_led_levels,
   input  logic [LEVELS_W-1:0]  rsp_blinking_mask,
   input  logic                 rsp_accepted,
   output int                   pending_beats,
   output int                   error_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [LEVELS_W-1:0] levels;
      logic [LEVELS_W-1:0] blinking;
      logic                accepted;
   } led_view_type;

   logic               lamp_level    [NCH];
   logic               lamp_blinking [NCH];
   logic               lamp_saved    [NCH];
   logic [TICKS_W-1:0] lamp_interval [NCH];
   logic [TICKS_W-1:0] lamp_elapsed  [NCH];
   logic [COUNT_W-1:0] lamp_left     [NCH];
   logic               lamp_forever  [NCH];

   led_view_type expected_views[$];

   function automatic void begin_blink(input int c, input logic [TICKS_W-1:0] ivl,
                                       input logic [COUNT_W-1:0] cnt, input logic forever_on);
      lamp_blinking[c] = 1'b1;
      lamp_saved[c]    = lamp_level[c];
      lamp_interval[c] = ivl;
      lamp_elapsed[c]  = '0;
      lamp_left[c]     = cnt;
      lamp_forever[c]  = forever_on;
   endfunction

   function automatic void end_blink(input int c);
      if (lamp_blinking[c]) begin
         lamp_blinking[c] = 1'b0;
         lamp_level[c]    = lamp_saved[c];
      end
   endfunction

   function automatic led_view_type apply_command(input logic [TYPE_W-1:0] code,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic lvl,
                                                  input logic [TICKS_W-1:0] ivl,
                                                  input logic [COUNT_W-1:0] cnt);
      led_view_type v;
      logic         ch_ok;
      int           c;
      v     = '0;
      c     = int'(idx);
      ch_ok = (c < NCH);
      case (code)
         REQ_SET: begin
            if (ch_ok) begin
               lamp_blinking[c] = 1'b0;
               lamp_level[c]    = lvl;
               v.accepted       = 1'b1;
            end
         end
         REQ_TOGGLE: begin
            if (ch_ok) begin
               lamp_blinking[c] = 1'b0;
               lamp_level[c]    = ~lamp_level[c];
               v.accepted       = 1'b1;
            end
         end
         REQ_BLINK_FOREVER: begin
            if (ch_ok && ivl != 0) begin
               begin_blink(c, ivl, '0, 1'b1);
               v.accepted = 1'b1;
            end
         end
         REQ_BLINK_OFF: begin
            if (ch_ok) begin
               end_blink(c);
               v.accepted = 1'b1;
            end
         end
         REQ_BLINK_TOGGLE: begin
            if (ch_ok && ivl != 0) begin
               if (lamp_blinking[c]) end_blink(c);
               else begin_blink(c, ivl, '0, 1'b1);
               v.accepted = 1'b1;
            end
         end
         REQ_BLINK_TIMES: begin
            if (ch_ok && ivl != 0 && cnt != 0) begin
               begin_blink(c, ivl, cnt, 1'b0);
               v.accepted = 1'b1;
            end
         end
         REQ_TICK: begin
            for (int i = 0; i < NCH; i++) begin
               if (lamp_blinking[i]) begin
                  lamp_elapsed[i] = lamp_elapsed[i] + 1'b1;
                  if (lamp_elapsed[i] >= lamp_interval[i]) begin
                     lamp_elapsed[i] = '0;
                     lamp_level[i]   = ~lamp_level[i];
                     // counted blink: one cycle done each time the saved level returns
                     if (!lamp_forever[i] && lamp_level[i] == lamp_saved[i]) begin
                        if (lamp_left[i] != 0) lamp_left[i] = lamp_left[i] - 1'b1;
                        if (lamp_left[i] == 0) lamp_blinking[i] = 1'b0;
                     end
                  end
               end
            end
            v.accepted = 1'b1;
         end
         default: ;
      endcase
      for (int i = 0; i < NCH && i < LEVELS_W; i++) begin
         v.levels[i]   = lamp_level[i];
         v.blinking[i] = lamp_blinking[i];
      end
      return v;
   endfunction

   always @(posedge clock) begin
      led_view_type want;
      int           bad;
      bad = 0;
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            lamp_level[i]    = 1'b0;
            lamp_blinking[i] = 1'b0;
            lamp_saved[i]    = 1'b0;
            lamp_interval[i] = '0;
            lamp_elapsed[i]  = '0;
            lamp_left[i]     = '0;
            lamp_forever[i]  = 1'b0;
         end
         expected_views.delete();
         pending_beats <= 0;
         error_count   <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_views.size() == 0) begin
               $display("%0t: unexpected result levels %h mask %h accepted %b",
                        $time, rsp_led_levels, rsp_blinking_mask, rsp_accepted);
               bad = 1;
            end else begin
               want = expected_views.pop_front();
               if (rsp_led_levels !== want.levels) begin
                  $display("%0t: led_levels expected %h actual %h",
                           $time, want.levels, rsp_led_levels);
                  bad++;
               end
               if (rsp_blinking_mask !== want.blinking) begin
                  $display("%0t: blinking_mask expected %h actual %h",
                           $time, want.blinking, rsp_blinking_mask);
                  bad++;
               end
               if (rsp_accepted !== want.accepted) begin
                  $display("%0t: accepted expected %b actual %b",
                           $time, want.accepted, rsp_accepted);
                  bad++;
               end
            end
         end
         if (start && !busy)
            expected_views.push_back(apply_command(req_type, req_led_index, req_level_on,
                                                   req_interval_ticks, req_blink_count));
         pending_beats <= expected_views.size();
         error_count   <= error_count + bad;
      end
   end

endmodule

/* verif/tb_multi_led_blink_controller.sv */
// ----------------------------------------------------------------------------
// tb_multi_led_blink_controller
// Drives command beats into the LED blink controller: a directed pass over
// every command and corner case, then random commands mixed with many ticks,
// with random sender gaps. The checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb_multi_led_blink_controller;

   import mlbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 850;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [TYPE_W-1:0]   req_type = REQ_TICK;
   logic [INDEX_W-1:0]  req_led_index = '0;
   logic                req_level_on = 1'b0;
   logic [TICKS_W-1:0]  req_interval_ticks = '0;
   logic [COUNT_W-1:0]  req_blink_count = '0;
   logic                rsp_valid;
   logic [LEVELS_W-1:0] rsp_led_levels;
   logic [LEVELS_W-1:0] rsp_blinking_mask;
   logic                rsp_accepted;
   int                  pending_beats;
   int                  error_count;
   int                  cycle_count = 0;
   bit                  no_gaps = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multi_led_blink_controller u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_led_index      (req_led_index),
      .req_level_on       (req_level_on),
      .req_interval_ticks (req_interval_ticks),
      .req_blink_count    (req_blink_count),
      .rsp_valid          (rsp_valid),
      .rsp_led_levels     (rsp_led_levels),
      .rsp_blinking_mask  (rsp_blinking_mask),
      .rsp_accepted       (rsp_accepted)
   );

   mlbc_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_led_index      (req_led_index),
      .req_level_on       (req_level_on),
      .req_interval_ticks (req_interval_ticks),
      .req_blink_count    (req_blink_count),
      .rsp_valid          (rsp_valid),
      .rsp_led_levels     (rsp_led_levels),
      .rsp_blinking_mask  (rsp_blinking_mask),
      .rsp_accepted       (rsp_accepted),
      .pending_beats      (pending_beats),
      .error_count        (error_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // start stays high on return; the caller lowers it for a gap
   task automatic send_beat(input logic [TYPE_W-1:0] code, input int idx, input logic lvl,
                            input int ivl, input int cnt);
      start              <= 1'b1;
      req_type           <= code;
      req_led_index      <= idx[INDEX_W-1:0];
      req_level_on       <= lvl;
      req_interval_ticks <= ivl[TICKS_W-1:0];
      req_blink_count    <= cnt[COUNT_W-1:0];
      do @(posedge clock); while (busy);
   endtask

   task automatic sender_gap();
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      gap  = 0;
      if (!no_gaps) begin
         if (roll < 25) gap = $urandom_range(1, 3);
         else if (roll < 30) gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   task automatic send_random();
      logic [TYPE_W-1:0] code;
      logic lvl;
      int roll;
      int idx;
      int ivl;
      int cnt;
      roll = $urandom_range(0, 99);
      if (roll < 45) code = REQ_TICK;
      else if (roll < 48) code = REQ_UNUSED;
      else code = TYPE_W'($urandom_range(REQ_SET, REQ_BLINK_TIMES));
      idx  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
      roll = $urandom_range(0, 99);
      if (roll < 8) ivl = 0;
      else if (roll < 20) ivl = $urandom_range(0, 65535);
      else ivl = $urandom_range(1, 4);
      roll = $urandom_range(0, 99);
      if (roll < 8) cnt = 0;
      else if (roll < 25) cnt = $urandom_range(0, 65535);
      else cnt = $urandom_range(1, 3);
      lvl = 1'($urandom_range(0, 1));
      send_beat(code, idx, lvl, ivl, cnt);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(REQ_TICK,          0,  1'b1, 0,     0);
      send_beat(REQ_SET,           0,  1'b1, 0,     0);
      send_beat(REQ_SET,           7,  1'b1, 65535, 65535);
      send_beat(REQ_SET,           8,  1'b1, 0,     0);
      send_beat(REQ_TOGGLE,        15, 1'b0, 0,     0);
      send_beat(REQ_TOGGLE,        0,  1'b0, 0,     0);
      send_beat(REQ_BLINK_OFF,     3,  1'b0, 0,     0);
      send_beat(REQ_BLINK_FOREVER, 1,  1'b0, 1,     0);
      send_beat(REQ_BLINK_TIMES,   2,  1'b0, 1,     1);
      send_beat(REQ_BLINK_TIMES,   4,  1'b0, 0,     1);
      send_beat(REQ_BLINK_TIMES,   4,  1'b0, 2,     0);
      send_beat(REQ_BLINK_TOGGLE,  5,  1'b0, 0,     0);
      send_beat(REQ_BLINK_TOGGLE,  5,  1'b0, 65535, 0);
      send_beat(REQ_BLINK_FOREVER, 6,  1'b0, 65535, 0);
      send_beat(REQ_BLINK_TIMES,   7,  1'b0, 1,     65535);
      send_beat(REQ_TICK,          9,  1'b1, 3,     3);
      send_beat(REQ_TICK,          0,  1'b0, 0,     0);
      send_beat(REQ_BLINK_FOREVER, 1,  1'b0, 2,     0);
      send_beat(REQ_BLINK_TOGGLE,  1,  1'b0, 0,     0);
      send_beat(REQ_BLINK_TOGGLE,  5,  1'b0, 1,     0);
      send_beat(REQ_UNUSED,        2,  1'b1, 1,     1);
      send_beat(REQ_TICK,          0,  1'b0, 0,     0);
      send_beat(REQ_BLINK_OFF,     1,  1'b0, 0,     0);
      send_beat(REQ_SET,           7,  1'b0, 0,     0);
      send_beat(REQ_TICK,          0,  1'b0, 0,     0);
      drain();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (n % 200 == 199) drain();
         send_random();
         sender_gap();
      end

      drain();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
